/* hdl/bsre_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bsre_pkg
// Types and constants shared by the scanline run-length encoder.
// ----------------------------------------------------------------------------
package bsre_pkg;

  // kind of the open run
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ZERO = 2'd1;
  localparam logic [1:0] KIND_ONES = 2'd2;
  localparam logic [1:0] KIND_LIT  = 2'd3;

  // byte values and limits of the code
  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONES = 8'hFF;
  localparam logic [7:0] CODE_MARK = 8'h80;
  localparam logic [6:0] SOLID_MAX = 7'd127;

  // input beat: one raw byte of a scanline
  typedef struct packed {
    logic [7:0] data_byte;
    logic       line_end;
  } pix_beat_t;

  // output beat: one byte of the coded scanline
  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
  } rle_beat_t;

endpackage : bsre_pkg
`default_nettype wire

/* hdl/bitmap_scanline_rle_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_scanline_rle_encoder
// Run-length coder for the bytes of a monochrome scanline.
// ----------------------------------------------------------------------------
// Takes one scanline byte per beat and codes runs of 0x00 as a count byte,
// runs of 0xFF as 128 plus the count, and runs of other bytes as 128, the
// count and the bytes themselves. Solid runs split at 127, literal runs at
// LITERAL_MAX, and no run crosses a line end. A byte that closes no run is
// taken at once while the coder is idle; a byte that closes runs holds the
// input while the single emit sequencer codes them, walking the literal
// store one entry per cycle through its registered read port as long as
// the output is not stalled by back-pressure. The literal store has no
// reset; only entries written for the open run are ever read.
module bitmap_scanline_rle_encoder
  import bsre_pkg::*;
#(
  parameter int LITERAL_MAX = 60
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            pix_valid,
  output logic           pix_ready,
  input  wire pix_beat_t pix,
  output logic           rle_valid,
  input  wire            rle_ready,
  output rle_beat_t      rle
);

  localparam int IW = (LITERAL_MAX > 1) ? $clog2(LITERAL_MAX) : 1;
  localparam logic [6:0] LIT_LIMIT = 7'(LITERAL_MAX);

  // sequencer states
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  // phases of one run close
  localparam logic [1:0] PH_HEAD  = 2'd0;
  localparam logic [1:0] PH_COUNT = 2'd1;
  localparam logic [1:0] PH_DATA  = 2'd2;

  // literal store
  logic [7:0] lit_mem [LITERAL_MAX];
  logic [7:0] rd_data;

  // open run
  logic [1:0] run_kind, run_kind_next;
  logic [6:0] run_count, run_count_next;

  // run being coded and the one queued behind it
  logic       st, st_next;
  logic [1:0] ph, ph_next;
  logic [1:0] cur_kind, cur_kind_next;
  logic [6:0] cur_count, cur_count_next;
  logic       pend, pend_next;
  logic [1:0] pend_kind, pend_kind_next;
  logic [6:0] pend_count, pend_count_next;
  logic [IW-1:0] rd_idx, rd_idx_next;

  logic       pix_accept;
  logic [1:0] in_kind;
  logic       close_old, close_new;
  logic [6:0] base_count, new_count;
  logic       load, fin;
  logic [7:0] beat_val;

  assign pix_ready  = (st == ST_IDLE);
  assign pix_accept = pix_valid && pix_ready;

  // classify the incoming byte
  always_comb begin
    if (pix.data_byte == BYTE_ZERO) begin
      in_kind = KIND_ZERO;
    end else if (pix.data_byte == BYTE_ONES) begin
      in_kind = KIND_ONES;
    end else begin
      in_kind = KIND_LIT;
    end
  end

  // which runs this byte closes
  assign close_old  = (run_kind != KIND_NONE) && (run_kind != in_kind);
  assign base_count = close_old ? 7'd0 : run_count;
  assign new_count  = base_count + 7'd1;
  assign close_new  = pix.line_end ||
                      ((in_kind == KIND_LIT) ? (new_count >= LIT_LIMIT)
                                             : (new_count >= SOLID_MAX));

  // code byte of the current phase
  assign load = (st == ST_EMIT) && (!rle_valid || rle_ready);

  always_comb begin
    beat_val = BYTE_ZERO;
    fin      = 1'b1;
    case (cur_kind)
      KIND_ZERO: beat_val = {1'b0, cur_count};
      KIND_ONES: beat_val = {1'b1, cur_count};
      KIND_LIT: begin
        case (ph)
          PH_HEAD: begin
            beat_val = CODE_MARK;
            fin      = 1'b0;
          end
          PH_COUNT: begin
            beat_val = {1'b0, cur_count};
            fin      = 1'b0;
          end
          default: begin
            beat_val = rd_data;
            fin      = ({{(7 - IW){1'b0}}, rd_idx} + 7'd1) == cur_count;
          end
        endcase
      end
      default: beat_val = BYTE_ZERO;
    endcase
  end

  // sequencer next state
  always_comb begin
    st_next         = st;
    ph_next         = ph;
    cur_kind_next   = cur_kind;
    cur_count_next  = cur_count;
    pend_next       = pend;
    pend_kind_next  = pend_kind;
    pend_count_next = pend_count;
    rd_idx_next     = rd_idx;
    run_kind_next   = run_kind;
    run_count_next  = run_count;

    if (pix_accept) begin
      // fold the byte into the open run
      run_kind_next   = close_new ? KIND_NONE : in_kind;
      run_count_next  = close_new ? 7'd0 : new_count;
      ph_next         = PH_HEAD;
      rd_idx_next     = '0;
      if (close_old) begin
        st_next         = ST_EMIT;
        cur_kind_next   = run_kind;
        cur_count_next  = run_count;
        pend_next       = close_new;
        pend_kind_next  = in_kind;
        pend_count_next = new_count;
      end else if (close_new) begin
        st_next        = ST_EMIT;
        cur_kind_next  = in_kind;
        cur_count_next = new_count;
        pend_next      = 1'b0;
      end
    end else if (load) begin
      if (fin) begin
        ph_next     = PH_HEAD;
        rd_idx_next = '0;
        if (pend) begin
          cur_kind_next  = pend_kind;
          cur_count_next = pend_count;
          pend_next      = 1'b0;
        end else begin
          st_next = ST_IDLE;
        end
      end else begin
        case (ph)
          PH_HEAD:  ph_next = PH_COUNT;
          PH_COUNT: ph_next = PH_DATA;
          default:  rd_idx_next = rd_idx + IW'(1);
        endcase
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= ST_IDLE;
      ph        <= PH_HEAD;
      pend      <= 1'b0;
      run_kind  <= KIND_NONE;
      run_count <= 7'd0;
      rd_idx    <= '0;
      cur_kind  <= KIND_NONE;
    end else begin
      st        <= st_next;
      ph        <= ph_next;
      pend      <= pend_next;
      run_kind  <= run_kind_next;
      run_count <= run_count_next;
      rd_idx    <= rd_idx_next;
      cur_kind  <= cur_kind_next;
    end
  end

  // payload of the queued closes
  always_ff @(posedge clk) begin
    cur_count  <= cur_count_next;
    pend_kind  <= pend_kind_next;
    pend_count <= pend_count_next;
  end

  // literal store: write on a literal byte, registered read of the next index
  always_ff @(posedge clk) begin
    if (pix_accept && (in_kind == KIND_LIT)) begin
      lit_mem[base_count[IW-1:0]] <= pix.data_byte;
    end
    rd_data <= lit_mem[rd_idx_next];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rle_valid <= 1'b0;
    end else if (load) begin
      rle_valid <= 1'b1;
    end else if (rle_ready) begin
      rle_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rle.code_byte <= beat_val;
      rle.last      <= fin && !pend;
    end
  end

  // checks
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (st == ST_IDLE) |-> !pend)
    else $error("queued close left behind in idle");

  a_none_empty: assert property (@(posedge clk) disable iff (rst)
    (run_kind == KIND_NONE) |-> (run_count == 7'd0))
    else $error("count held with no open run");

  a_lit_bound: assert property (@(posedge clk) disable iff (rst)
    (run_kind == KIND_LIT) |-> (run_count != 7'd0) && (run_count < LIT_LIMIT))
    else $error("open literal run out of bounds");

  a_rd_bound: assert property (@(posedge clk) disable iff (rst)
    (st == ST_EMIT) && (cur_kind == KIND_LIT) && (ph == PH_DATA)
      |-> ({{(7 - IW){1'b0}}, rd_idx} < cur_count))
    else $error("literal read past the run");

  a_close_emits: assert property (@(posedge clk) disable iff (rst)
    pix_accept && (close_old || close_new) |=> (st == ST_EMIT))
    else $error("closed run not coded");

endmodule : bitmap_scanline_rle_encoder
`default_nettype wire

/* test/tb_bitmap_scanline_rle_encoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bitmap_scanline_rle_encoder
// Self-checking bench for the scanline run-length encoder.
// ----------------------------------------------------------------------------
// Feeds scanline bytes through the pix channel and compares every code beat
// against a run tracker that models the zero, 0xFF and literal runs with
// their splits at 127 and LITERAL_MAX. A short directed section is followed
// by long runs that hit the split points, then random short runs with noise.
// The sender idles in bursts, the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb_bitmap_scanline_rle_encoder;
  import bsre_pkg::*;

  localparam int LITERAL_MAX = 60;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = 100;
  localparam int RANDOM_END  = 425;
  localparam int PRINT_CAP   = 40;

  typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_CHOKE} rx_mode_e;

  // run tracker: models the coder and holds the code bytes still to come
  class rle_run_tracker;
    logic [1:0] run_kind;
    logic [6:0] run_count;
    logic [7:0] lit_store [LITERAL_MAX];
    rle_beat_t  pending_codes [$];
    int         errors;

    function new();
      run_kind  = KIND_NONE;
      run_count = '0;
      errors    = 0;
    endfunction

    task report(input string msg);
      if (errors < PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    function void push_code(input logic [7:0] b);
      rle_beat_t c;
      c.code_byte = b;
      c.last      = 1'b0;
      pending_codes.push_back(c);
    endfunction

    // code the open run and leave no run open
    function void close_run();
      case (run_kind)
        KIND_ZERO: push_code({1'b0, run_count});
        KIND_ONES: push_code(CODE_MARK | {1'b0, run_count});
        KIND_LIT: begin
          push_code(CODE_MARK);
          push_code({1'b0, run_count});
          for (int i = 0; i < run_count && i < LITERAL_MAX; i++) push_code(lit_store[i]);
        end
        default: ;
      endcase
      run_kind  = KIND_NONE;
      run_count = '0;
    endfunction

    function void take_pixel_byte(input pix_beat_t p);
      logic [1:0] kind;
      int         first;
      rle_beat_t  tail;
      first = pending_codes.size();
      if (p.data_byte == BYTE_ZERO) kind = KIND_ZERO;
      else if (p.data_byte == BYTE_ONES) kind = KIND_ONES;
      else kind = KIND_LIT;
      // a change of kind closes the open run first
      if (run_kind != KIND_NONE && run_kind != kind) close_run();
      run_kind = kind;
      if (kind == KIND_LIT) begin
        if (run_count < LITERAL_MAX) lit_store[run_count] = p.data_byte;
        run_count = run_count + 7'd1;
        if (run_count >= LITERAL_MAX) close_run();
      end else begin
        run_count = run_count + 7'd1;
        if (run_count >= SOLID_MAX) close_run();
      end
      // no run crosses a line end
      if (p.line_end) close_run();
      if (pending_codes.size() > first) begin
        tail = pending_codes[pending_codes.size() - 1];
        tail.last = 1'b1;
        pending_codes[pending_codes.size() - 1] = tail;
      end
    endfunction

    task check_code_byte(input rle_beat_t got);
      rle_beat_t want;
      if (pending_codes.size() == 0) begin
        report($sformatf("unexpected code beat %02h last %0b", got.code_byte, got.last));
      end else begin
        want = pending_codes.pop_front();
        if (got.code_byte !== want.code_byte)
          report($sformatf("code_byte %02h, expected %02h", got.code_byte, want.code_byte));
        if (got.last !== want.last)
          report($sformatf("last %0b on code %02h, expected %0b",
                           got.last, got.code_byte, want.last));
      end
    endtask
  endclass

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      pix_valid = 1'b0;
  logic      pix_ready;
  pix_beat_t pix       = '0;
  logic      rle_valid;
  logic      rle_ready = 1'b0;
  rle_beat_t rle;

  rle_run_tracker tracker = new();

  int       burst_left = 0;
  int       sent_bytes = 0;
  int       idle_cycles = 0;
  rx_mode_e rx_mode = RX_STREAM;
  int       rx_left = 0;

  bitmap_scanline_rle_encoder #(
    .LITERAL_MAX (LITERAL_MAX)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix       (pix),
    .rle_valid (rle_valid),
    .rle_ready (rle_ready),
    .rle       (rle)
  );

  always #2 clk = ~clk;

  // beat monitor: input noted before output so same-edge results line up
  always @(posedge clk) begin
    if (!rst) begin
      if (pix_valid && pix_ready) tracker.take_pixel_byte(pix);
      if (rle_valid && rle_ready) tracker.check_code_byte(rle);
    end
  end

  // receiver stall pattern: free streaming, coin flips, or mostly choked
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_e'($urandom_range(0, 2));
      rx_left <= $urandom_range(8, 60);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RX_STREAM: rle_ready <= 1'b1;
      RX_RANDOM: rle_ready <= 1'($urandom_range(0, 1));
      default:   rle_ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if ((pix_valid && pix_ready) || (rle_valid && rle_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("bitmap_scanline_rle_encoder verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one scanline byte, with bursts and gaps on the sender side
  task automatic send_pix(input logic [7:0] b, input logic le);
    pix_beat_t beat;
    int        gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        pix_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    beat.data_byte = b;
    beat.line_end  = le;
    pix_valid <= 1'b1;
    pix       <= beat;
    do @(posedge clk); while (!pix_ready);
    burst_left--;
    sent_bytes++;
  endtask

  // hold the sender until every outstanding code byte has come out
  task automatic drain_codes();
    pix_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (tracker.pending_codes.size() != 0);
  endtask

  // a run of one kind with random content, optionally with noise
  task automatic send_run(input logic [1:0] kind, input int len, input bit end_line,
                          input bit noisy);
    logic [7:0] b;
    logic       le;
    for (int i = 0; i < len; i++) begin
      if (kind == KIND_ZERO) b = BYTE_ZERO;
      else if (kind == KIND_ONES) b = BYTE_ONES;
      else b = 8'($urandom_range(1, 254));
      if (noisy && $urandom_range(0, 29) == 0) b = 8'($urandom_range(0, 255));
      le = (end_line && i == len - 1) || (noisy && $urandom_range(0, 24) == 0);
      send_pix(b, le);
    end
  endtask

  initial begin
    logic [1:0] kind;
    int         len;
    int         pick;

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single-byte lines of each kind
    send_pix(8'h00, 1'b1);
    send_pix(8'hFF, 1'b1);
    send_pix(8'h01, 1'b1);
    // literal run closed by a change of kind, then zero run closed by 0xFF
    send_pix(8'hFE, 1'b0);
    send_pix(8'h80, 1'b0);
    send_pix(8'h7F, 1'b0);
    send_pix(8'h00, 1'b0);
    send_pix(8'h00, 1'b0);
    send_pix(8'hFF, 1'b0);
    send_pix(8'hFF, 1'b0);
    send_pix(8'h55, 1'b0);
    send_pix(8'hAA, 1'b1);
    // change of kind and line end on the same byte
    send_pix(8'hFF, 1'b0);
    send_pix(8'h00, 1'b1);
    send_pix(8'h00, 1'b0);
    send_pix(8'h00, 1'b0);
    send_pix(8'h00, 1'b1);
    send_pix(8'h01, 1'b0);
    send_pix(8'hFF, 1'b1);
    drain_codes();

    // long runs across the solid and literal split points
    send_run(KIND_ZERO, $urandom_range(127, 131), 1'b1, 1'b0);
    send_run(KIND_ONES, $urandom_range(127, 131), 1'b1, 1'b0);
    send_run(KIND_LIT, $urandom_range(60, 64), 1'b1, 1'b0);
    drain_codes();

    // random short runs with stray bytes and stray line ends
    while (sent_bytes < RANDOM_END) begin
      pick = $urandom_range(0, 9);
      if (pick < 3) kind = KIND_ZERO;
      else if (pick < 6) kind = KIND_ONES;
      else kind = KIND_LIT;
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(10, 70) : $urandom_range(1, 9);
      send_run(kind, len, ($urandom_range(0, 2) == 0), 1'b1);
    end
    send_pix(8'h33, 1'b1);
    drain_codes();

    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.pending_codes.size() != 0)
      tracker.report($sformatf("%0d code bytes never came", tracker.pending_codes.size()));
    if (tracker.errors == 0) begin
      $display("bitmap_scanline_rle_encoder verification clean");
    end else begin
      $display("bitmap_scanline_rle_encoder verification failed");
    end
    $finish;
  end

endmodule

/* bitmap_scanline_rle_encoder.f */
hdl/bsre_pkg.sv
hdl/bitmap_scanline_rle_encoder.sv
test/tb_bitmap_scanline_rle_encoder.sv
